[design/bms_pkg.sv]
// Package for the bounded membership set: request codes, field types and the
// control bundle that the top level broadcasts to every storage cell.
// No dependencies.
package bms_pkg;

	localparam int KEY_W = 32;
	localparam int OP_W  = 2;
	localparam int OCC_W = 5;

	typedef logic [OP_W-1:0]         op_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [OCC_W-1:0]        occ_t;

	localparam op_t OP_CONTAINS = 2'd0;
	localparam op_t OP_ADD      = 2'd1;
	localparam op_t OP_REMOVE   = 2'd2;

	// Control that every cell sees in the same cycle.
	typedef struct packed {
		logic cmp_en;    // compare cmp_key against the stored key
		key_t cmp_key;
		logic remove_en; // close the gap left by the matching cell
		logic add_en;    // first free cell takes new_key
		key_t new_key;
	} cell_ctrl_t;

endpackage

[design/bounded_membership_set.sv]
// Bounded membership set: top level with the request handshake, the cell chain
// and the result register. Depends on bms_pkg and bms_cell.
//
// Holds up to CAPACITY distinct 32-bit keys and answers contains, add and
// remove requests with one result beat each (found/inserted/removed flag, a
// full status for a rejected add, and the key count afterwards). In the cycle
// a request is accepted every cell compares its key in parallel; in the next
// cycle the match and the first free cell ripple along the cell chain and the
// chain updates while the result is registered. No new request is taken while
// one is in progress or while a result beat waits on an output stall.
module bounded_membership_set #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bms_pkg::op_t      operation,
	input  bms_pkg::key_t     key,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              done_res,
	output logic              status,
	output bms_pkg::occ_t     occupancy
);
	import bms_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic             busy_q;
	op_t              op_s1;
	key_t             key_s1;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic             done_q;
	logic             status_q;

	logic             accept;
	cell_ctrl_t       ctrl;
	logic [CAPACITY-1:0] valid_w;
	key_t             key_w [CAPACITY];
	logic [CAPACITY:0] hit_chain;
	logic             found;
	logic             full;
	logic             add_ok;
	logic             rem_ok;
	logic             done_d;
	logic             status_d;
	logic [CNT_W+OCC_W-1:0] count_ext;

	assign in_stall = busy_q | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	assign found  = hit_chain[CAPACITY];
	assign full   = valid_w[CAPACITY-1];
	assign add_ok = busy_q && (op_s1 == OP_ADD) && !found && !full;
	assign rem_ok = busy_q && (op_s1 == OP_REMOVE) && found;

	always_comb begin
		ctrl.cmp_en    = accept;
		ctrl.cmp_key   = key;
		ctrl.remove_en = rem_ok;
		ctrl.add_en    = add_ok;
		ctrl.new_key   = key_s1;
	end

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic prev_v;
		logic up_v;
		key_t up_k;
		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign up_v = 1'b0;
			assign up_k = '0;
		end else begin : g_up
			assign up_v = valid_w[i+1];
			assign up_k = key_w[i+1];
		end
		bms_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prev_valid(prev_v),
			.up_valid  (up_v),
			.up_key    (up_k),
			.hit_in    (hit_chain[i]),
			.hit_out   (hit_chain[i+1]),
			.valid     (valid_w[i]),
			.key       (key_w[i])
		);
	end

	always_comb begin
		done_d   = 1'b0;
		status_d = 1'b0;
		case (op_s1)
			OP_CONTAINS: done_d = found;
			OP_ADD: begin
				done_d   = !found && !full;
				status_d = !found && full;
			end
			OP_REMOVE:   done_d = found;
			default: begin
				done_d   = 1'b0;
				status_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q <= accept;
			if (add_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rem_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= operation;
			key_s1 <= key;
		end
		if (busy_q) begin
			done_q   <= done_d;
			status_q <= status_d;
		end
	end

	// The occupancy beat always shows the current count, which only moves
	// in the cycle that also loads the result register.
	assign count_ext = {{OCC_W{1'b0}}, count_q};

	assign out_valid = out_valid_q;
	assign done_res  = done_q;
	assign status    = status_q;
	assign occupancy = count_ext[OCC_W-1:0];

endmodule

[design/bms_cell.sv]
// One storage cell of the membership set chain: a key, its valid flag and the
// registered match flag. Depends on bms_pkg.
// Cells stay packed: valid cells always form the low end of the chain.
module bms_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bms_pkg::cell_ctrl_t ctrl,
	input  logic              prev_valid,
	input  logic              up_valid,
	input  bms_pkg::key_t     up_key,
	input  logic              hit_in,
	output logic              hit_out,
	output logic              valid,
	output bms_pkg::key_t     key
);
	import bms_pkg::*;

	logic valid_q;
	key_t key_q;
	logic hit_s1;

	assign valid   = valid_q;
	assign key     = key_q;
	assign hit_out = hit_in | hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_s1  <= 1'b0;
		end else begin
			if (ctrl.cmp_en) begin
				hit_s1 <= valid_q && (key_q == ctrl.cmp_key);
			end
			// A removal at or below this cell pulls the upper neighbor down.
			if (ctrl.remove_en && hit_out) begin
				valid_q <= up_valid;
			end else if (ctrl.add_en && !valid_q && prev_valid) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.remove_en && hit_out) begin
			key_q <= up_key;
		end else if (ctrl.add_en && !valid_q && prev_valid) begin
			key_q <= ctrl.new_key;
		end
	end

endmodule

[dv/tb_bounded_membership_set.sv]
// Self-checking testbench for bounded_membership_set: directed and random contains/add/remove
// requests, checked beat by beat against an in-bench model of the key set.
// Depends on bms_pkg and the bounded_membership_set RTL.
module tb_bounded_membership_set;
	timeunit 1ns;
	timeprecision 1ps;
	import bms_pkg::*;

	localparam int SLOTS = 16;
	localparam int POOL_SIZE = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_PRINTED = 50;
	localparam op_t OP_UNUSED = 2'd3;

	typedef struct {
		op_t op;
		key_t k;
	} request_t;

	typedef struct {
		logic found;
		logic full;
		occ_t count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	op_t operation = OP_CONTAINS;
	key_t key = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic done_res;
	logic status;
	occ_t occupancy;

	request_t pending_requests[$];
	outcome_t outcomes_due[$];

	// Model of the key set; slot order does not matter, only membership and count.
	key_t set_keys[SLOTS];
	logic set_used[SLOTS] = '{default: 1'b0};
	int unsigned set_size = 0;

	key_t key_pool[POOL_SIZE];
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic rx_hold = 1'b0;
	int errors = 0;
	int unsigned cycle_count = 0;

	bounded_membership_set #(
		.CAPACITY(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.done_res(done_res),
		.status(status),
		.occupancy(occupancy)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		if (errors < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// Updates the set for one accepted request and queues the result it must produce.
	function automatic void apply_request(op_t op, key_t k);
		int hit;
		int free_slot;
		outcome_t res;
		hit = -1;
		free_slot = -1;
		res = '{found: 1'b0, full: 1'b0, count: '0};
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (set_used[i] && set_keys[i] == k)
				hit = i;
			if (!set_used[i])
				free_slot = i;
		end
		case (op)
			OP_CONTAINS: begin
				res.found = (hit >= 0);
			end
			OP_ADD: begin
				if (hit < 0) begin
					if (free_slot >= 0) begin
						set_keys[free_slot] = k;
						set_used[free_slot] = 1'b1;
						set_size++;
						res.found = 1'b1;
					end else begin
						res.full = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					set_used[hit] = 1'b0;
					set_size--;
					res.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.count = occ_t'(set_size);
		outcomes_due.push_back(res);
	endfunction

	// Request driver: a new beat is offered only once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		request_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				apply_request(operation, key);
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					operation <= next_req.op;
					key <= next_req.k;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and output-side stall generator.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing outstanding (%0b %0b %0d)",
						done_res, status, occupancy));
				end else begin
					want = outcomes_due.pop_front();
					if (done_res !== want.found)
						report_mismatch($sformatf("done_res got %0b expected %0b",
							done_res, want.found));
					if (status !== want.full)
						report_mismatch($sformatf("status got %0b expected %0b",
							status, want.full));
					if (occupancy !== want.count)
						report_mismatch($sformatf("occupancy got %0d expected %0d",
							occupancy, want.count));
				end
			end
			out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
		end
	end

	task automatic queue_request(op_t op, key_t k);
		request_t r;
		r.op = op;
		r.k = k;
		pending_requests.push_back(r);
	endtask

	// Mostly keys from a small pool so that hits, duplicates and a full set are common.
	task automatic queue_random(int n, int add_pct, int rem_pct);
		int r;
		op_t op;
		key_t k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 2)
				op = OP_UNUSED;
			else if (r < 2 + add_pct)
				op = OP_ADD;
			else if (r < 2 + add_pct + rem_pct)
				op = OP_REMOVE;
			else
				op = OP_CONTAINS;
			if ($urandom_range(99) < 80)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = key_t'($urandom);
			queue_request(op, k);
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || outcomes_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		key_pool[0] = key_t'(32'h8000_0000);
		key_pool[1] = key_t'(32'h7fff_ffff);
		key_pool[2] = key_t'(32'h0000_0000);
		key_pool[3] = key_t'(32'hffff_ffff);
		key_pool[4] = key_t'(32'h0000_0001);
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = key_t'($urandom);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Empty set first, then the key extremes, duplicates, the unused code and a full set.
		queue_request(OP_CONTAINS, key_t'(32'h0000_0000));
		queue_request(OP_REMOVE, key_t'(32'h8000_0000));
		queue_request(OP_ADD, key_t'(32'h8000_0000));
		queue_request(OP_ADD, key_t'(32'h7fff_ffff));
		queue_request(OP_ADD, key_t'(32'hffff_ffff));
		queue_request(OP_ADD, key_t'(32'h0000_0000));
		queue_request(OP_ADD, key_t'(32'h0000_0000));
		queue_request(OP_CONTAINS, key_t'(32'h8000_0000));
		queue_request(OP_UNUSED, key_t'(32'h7fff_ffff));
		queue_request(OP_REMOVE, key_t'(32'h7fff_ffff));
		queue_request(OP_REMOVE, key_t'(32'h7fff_ffff));
		for (int i = 0; i < SLOTS - 3; i++)
			queue_request(OP_ADD, key_t'(32'h0000_1000 + i));
		queue_request(OP_ADD, key_t'(32'h5555_aaaa));
		queue_request(OP_ADD, key_t'(32'hffff_ffff));
		queue_request(OP_REMOVE, key_t'(32'h0000_1000 + SLOTS - 4));
		wait_drained();

		queue_random(70, 50, 20);
		wait_drained();

		send_idle_pct = 54;
		queue_random(60, 35, 35);
		wait_drained();

		send_idle_pct = 0;
		stall_pct = 54;
		queue_random(60, 35, 35);
		wait_drained();

		send_idle_pct = 18;
		stall_pct = 18;
		queue_random(60, 30, 40);
		wait_drained();

		// Output held off long enough for the block to back up and stall its input.
		send_idle_pct = 0;
		stall_pct = 0;
		rx_hold = 1'b1;
		queue_random(40, 40, 30);
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
		wait_drained();

		send_idle_pct = 18;
		stall_pct = 18;
		queue_random(70, 20, 55);
		wait_drained();

		send_idle_pct = 0;
		stall_pct = 0;
		queue_random(40, 50, 20);
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
design/bms_pkg.sv
design/bms_cell.sv
design/bounded_membership_set.sv
dv/tb_bounded_membership_set.sv
